### sv/rcpf_pkg.sv
// Shared types, constants and the CRC step for the RC channel packet framer.
// No dependencies; every other file of the block imports this package.
package rcpf_pkg;

    // Defaults for the top-level parameters
    localparam int CHANNEL_COUNT_DEF  = 16;
    localparam int PROTO_VERSION_DEF  = 1;
    localparam int THROTTLE_INDEX_DEF = 2;

    // Port widths
    localparam int IN_TDATA_W = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CHAN_IDX_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINK_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGIC_WORD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINK_IDENT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SEND_INTERVAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_BURST    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MID_US        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_US        = 3'd7;

    // Register reset values
    localparam logic [15:0] HOLD_RESET     = 16'd500;
    localparam logic [9:0]  INTERVAL_RESET = 10'd20;
    localparam logic [15:0] STOP_RESET     = 16'd500;
    localparam logic [15:0] MID_RESET      = 16'd1500;
    localparam logic [15:0] MIN_RESET      = 16'd1000;

    // Packet layout
    localparam int          HDR_BYTES     = 18;
    localparam logic [7:0]  FLAGS_DIRECT  = 8'h03;
    localparam logic [7:0]  FLAGS_TRAINER = 8'h04;
    localparam logic [7:0]  FLAGS_IDLE    = 8'h00;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'h1021;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_DIRECT  = 2'd1,
        MODE_TRAINER = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_COPY,
        ST_TICK,
        ST_SEND
    } state_t;

    // Control toward the channel/staging memories
    typedef struct packed {
        logic                  stg_we;
        logic [CHAN_IDX_W-1:0] stg_idx;
        logic [15:0]           stg_val;
        logic                  copy_start;
    } store_ctrl_t;

    // Packet launch command toward the serializer
    typedef struct packed {
        logic        start;
        mode_t       mode;
        logic [15:0] seq;
        logic [31:0] now;
    } tx_cmd_t;

    // Configuration the serializer needs while a packet is out
    typedef struct packed {
        logic [31:0] magic;
        logic [31:0] ident;
        logic [15:0] mid_us;
        logic [15:0] min_us;
    } link_cfg_t;

    // One byte of CRC-16 CCITT, MSB first, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### sv/rc_channel_packet_framer.sv
// Top level of the RC channel packet framer: configuration registers, link
// state and the control sequencer. Depends on rcpf_pkg, rcpf_store, rcpf_tx.
//
// Frames arrive one channel element per transfer on the s_ side (s_tuser low);
// each element lands in a staging memory and the element with s_tlast high
// applies the frame. After a frame element that is not the last, s_tready
// stays high. The applying element holds s_tready low while the sequencer
// decides; when it selects a mode, also while the staging memory is copied
// into the channel memory one entry per cycle through its single read port
// (the decision, a read per entry, the last write and the return to idle).
// A tick (s_tuser high) holds s_tready low while it is qualified and, when
// it sends, until the serializer has pushed the packet one byte per cycle
// through its output register while m_tready does not stall. The next input
// transfer can be taken while the last CRC byte still waits on the m_ side.
// Packets are little endian: magic, link id, version, channel count, flags,
// reserved, sequence, time, channel words and a CRC-16 CCITT (seed 0xFFFF)
// over everything before it. No clearing pass follows reset; the channel
// memory reads as its reset values until the first applied frame has been
// copied in.
module rc_channel_packet_framer #(
    parameter int CHANNEL_COUNT  = rcpf_pkg::CHANNEL_COUNT_DEF,
    parameter int PROTO_VERSION  = rcpf_pkg::PROTO_VERSION_DEF,
    parameter int THROTTLE_INDEX = rcpf_pkg::THROTTLE_INDEX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [3:0] channel_index, [19:4] channel_value, [20] has_channels,
    // [21] trainer_enabled, [22] direct_enabled, [23] user_confirmed,
    // [55:24] now_ms
    input  logic [rcpf_pkg::IN_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,   // frame_last
    input  logic                              s_tuser,   // req_type
    // Result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] packet_byte
    output logic                              m_tlast,   // byte_last
    // Configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcpf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_data
);
    import rcpf_pkg::*;

    localparam int CIW = $clog2(CHANNEL_COUNT);

    // Configuration registers
    logic        link_enable_reg;
    logic [31:0] magic_reg;
    logic [31:0] ident_reg;
    logic [15:0] hold_reg;
    logic [9:0]  interval_reg;
    logic [15:0] stop_burst_reg;
    logic [15:0] mid_reg;
    logic [15:0] min_reg;

    // Link state
    state_t      state_reg;
    state_t      state_next;
    mode_t       link_mode_reg;
    logic        confirmed_reg;
    logic [31:0] last_frame_reg;
    logic [31:0] stop_until_reg;
    logic [31:0] next_send_reg;
    logic [15:0] seq_reg;

    // Captured item
    logic [31:0] now_reg;
    logic        has_ch_reg;
    logic        trainer_reg;
    logic        direct_reg;
    logic        confirm_in_reg;

    logic        in_xfer;
    mode_t       want_mode;
    mode_t       eff_mode;
    logic [31:0] age;
    logic [31:0] stop_diff;
    logic [31:0] send_diff;
    logic        live;
    logic        stopping;
    logic        send_ok;

    store_ctrl_t         store_ctrl;
    tx_cmd_t             tx_cmd;
    link_cfg_t           link_cfg;
    logic [CIW-1:0]      rd_addr;
    logic [15:0]         rd_word;
    logic                store_busy;
    logic                tx_busy;

    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Register file: accept a write every cycle, drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_enable_reg <= 1'b0;
            magic_reg       <= '0;
            ident_reg       <= '0;
            hold_reg        <= HOLD_RESET;
            interval_reg    <= INTERVAL_RESET;
            stop_burst_reg  <= STOP_RESET;
            mid_reg         <= MID_RESET;
            min_reg         <= MIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LINK_ENABLE:   link_enable_reg <= cfg_data[0];
                REG_MAGIC_WORD:    magic_reg       <= cfg_data;
                REG_LINK_IDENT:    ident_reg       <= cfg_data;
                REG_HOLD_MS:       hold_reg        <= cfg_data[15:0];
                REG_SEND_INTERVAL: interval_reg    <= cfg_data[9:0];
                REG_STOP_BURST:    stop_burst_reg  <= cfg_data[15:0];
                REG_MID_US:        mid_reg         <= cfg_data[15:0];
                REG_MIN_US:        min_reg         <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // Mode request carried by the applying element
    always_comb
    begin
        priority if (has_ch_reg && direct_reg && confirm_in_reg)
        begin
            want_mode = MODE_DIRECT;
        end
        else if (has_ch_reg && trainer_reg && !direct_reg)
        begin
            want_mode = MODE_TRAINER;
        end
        else
        begin
            want_mode = MODE_NONE;
        end
    end

    // Tick qualification: hold age, stop burst and send spacing, wrapped time
    assign age       = now_reg - last_frame_reg;
    assign stop_diff = now_reg - stop_until_reg;
    assign send_diff = now_reg - next_send_reg;
    assign live      = (age <= {16'h0000, hold_reg});
    assign stopping  = stop_diff[31];

    always_comb
    begin
        priority if (link_mode_reg == MODE_DIRECT && confirmed_reg && live)
        begin
            eff_mode = MODE_DIRECT;
        end
        else if (link_mode_reg == MODE_TRAINER && live)
        begin
            eff_mode = MODE_TRAINER;
        end
        else
        begin
            eff_mode = MODE_NONE;
        end
    end

    assign send_ok = link_enable_reg && (eff_mode != MODE_NONE || stopping) && !send_diff[31];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    priority if (s_tuser)
                    begin
                        state_next = ST_TICK;
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_APPLY;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_APPLY:
            begin
                state_next = (want_mode == MODE_NONE) ? ST_IDLE : ST_COPY;
            end
            ST_COPY:
            begin
                if (!store_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                state_next = send_ok ? ST_SEND : ST_IDLE;
            end
            ST_SEND:
            begin
                if (!tx_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready              = (state_reg == ST_IDLE);
        store_ctrl.stg_we     = (state_reg == ST_IDLE) && s_tvalid && !s_tuser;
        store_ctrl.stg_idx    = s_tdata[3:0];
        store_ctrl.stg_val    = s_tdata[19:4];
        store_ctrl.copy_start = (state_reg == ST_APPLY) && (want_mode != MODE_NONE);
        tx_cmd.start          = (state_reg == ST_TICK) && send_ok;
        tx_cmd.mode           = eff_mode;
        tx_cmd.seq            = seq_reg;
        tx_cmd.now            = now_reg;
    end

    assign link_cfg.magic  = magic_reg;
    assign link_cfg.ident  = ident_reg;
    assign link_cfg.mid_us = mid_reg;
    assign link_cfg.min_us = min_reg;

    // Link state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            link_mode_reg  <= MODE_NONE;
            confirmed_reg  <= 1'b0;
            last_frame_reg <= '0;
            stop_until_reg <= '0;
            next_send_reg  <= '0;
            seq_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_APPLY)
            begin
                if (want_mode == MODE_NONE)
                begin
                    // Start the idle burst only when a mode actually drops
                    if (link_mode_reg != MODE_NONE)
                    begin
                        stop_until_reg <= now_reg + {16'h0000, stop_burst_reg};
                    end
                    link_mode_reg <= MODE_NONE;
                    confirmed_reg <= 1'b0;
                end
                else
                begin
                    link_mode_reg  <= want_mode;
                    confirmed_reg  <= (want_mode == MODE_DIRECT);
                    last_frame_reg <= now_reg;
                end
            end
            if (tx_cmd.start)
            begin
                next_send_reg <= now_reg + {22'h000000, interval_reg};
                seq_reg       <= seq_reg + 16'd1;
            end
        end
    end

    // Capture the accepted item
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            has_ch_reg     <= s_tdata[20];
            trainer_reg    <= s_tdata[21];
            direct_reg     <= s_tdata[22];
            confirm_in_reg <= s_tdata[23];
            now_reg        <= s_tdata[55:24];
        end
    end

    rcpf_store #(
        .CHANNEL_COUNT  (CHANNEL_COUNT),
        .THROTTLE_INDEX (THROTTLE_INDEX)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (store_ctrl),
        .rd_addr (rd_addr),
        .rd_word (rd_word),
        .busy    (store_busy)
    );

    rcpf_tx #(
        .CHANNEL_COUNT  (CHANNEL_COUNT),
        .PROTO_VERSION  (PROTO_VERSION),
        .THROTTLE_INDEX (THROTTLE_INDEX)
    ) u_tx (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (tx_cmd),
        .cfg      (link_cfg),
        .rd_addr  (rd_addr),
        .rd_word  (rd_word),
        .busy     (tx_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        tx_cmd.start |=> seq_reg == $past(seq_reg) + 16'd1)
        else $error("sequence number did not advance on a sent packet");
    a_send_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        tx_cmd.start |-> link_enable_reg)
        else $error("packet launched with the link disabled");
    a_copy_mode: assert property (@(posedge clk) disable iff (!rst_n)
        store_ctrl.copy_start |=> link_mode_reg != MODE_NONE)
        else $error("channel copy without a live mode");
    a_send_no_copy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SEND |-> !store_busy)
        else $error("packet serialized while channel copy is running");
`endif

endmodule

### sv/rcpf_store.sv
// Channel and staging memories with the frame copy sequencer.
// Depends on rcpf_pkg.
module rcpf_store #(
    parameter int CHANNEL_COUNT  = rcpf_pkg::CHANNEL_COUNT_DEF,
    parameter int THROTTLE_INDEX = rcpf_pkg::THROTTLE_INDEX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rcpf_pkg::store_ctrl_t              ctrl,
    input  logic [$clog2(CHANNEL_COUNT)-1:0]   rd_addr,
    output logic [15:0]                        rd_word,
    output logic                               busy
);
    import rcpf_pkg::*;

    localparam int CIW = $clog2(CHANNEL_COUNT);

    logic [15:0]    stg_mem [CHANNEL_COUNT];
    logic [15:0]    chan_mem [CHANNEL_COUNT];

    logic           copy_act_reg;
    logic [CIW-1:0] copy_cnt_reg;
    logic           wr_pend_reg;
    logic [CIW-1:0] wr_addr_reg;
    logic           chan_init_reg;
    logic [15:0]    stg_q_reg;
    logic [15:0]    chan_q_reg;
    logic [CIW-1:0] rd_idx_reg;
    logic           stg_idx_ok;
    logic [15:0]    rst_word;

    assign stg_idx_ok = ({1'b0, ctrl.stg_idx} < 5'(CHANNEL_COUNT));
    assign busy       = copy_act_reg | wr_pend_reg;

    // Staging memory: element writes, copy reads
    always_ff @(posedge clk)
    begin
        if (ctrl.stg_we && stg_idx_ok)
        begin
            stg_mem[ctrl.stg_idx[CIW-1:0]] <= ctrl.stg_val;
        end
        stg_q_reg <= stg_mem[copy_cnt_reg];
    end

    // Channel memory: copy writes, serializer reads
    always_ff @(posedge clk)
    begin
        if (wr_pend_reg)
        begin
            chan_mem[wr_addr_reg] <= stg_q_reg;
        end
        chan_q_reg <= chan_mem[rd_addr];
        rd_idx_reg <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_act_reg  <= 1'b0;
            copy_cnt_reg  <= '0;
            wr_pend_reg   <= 1'b0;
            wr_addr_reg   <= '0;
            chan_init_reg <= 1'b0;
        end
        else
        begin
            wr_pend_reg <= copy_act_reg;
            wr_addr_reg <= copy_cnt_reg;
            if (ctrl.copy_start)
            begin
                copy_act_reg <= 1'b1;
                copy_cnt_reg <= '0;
            end
            else if (copy_act_reg)
            begin
                if (copy_cnt_reg == CIW'(CHANNEL_COUNT - 1))
                begin
                    copy_act_reg <= 1'b0;
                end
                else
                begin
                    copy_cnt_reg <= copy_cnt_reg + 1'b1;
                end
            end
            // Last copy write done: the memory now holds every entry
            if (wr_pend_reg && !copy_act_reg)
            begin
                chan_init_reg <= 1'b1;
            end
        end
    end

    // Until the first copy, entries read as their reset values
    assign rst_word = (5'(rd_idx_reg) == 5'(THROTTLE_INDEX)) ? MIN_RESET : MID_RESET;
    assign rd_word  = chan_init_reg ? chan_q_reg : rst_word;

`ifndef NO_ASSERTIONS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.copy_start |-> !busy)
        else $error("copy started while a copy was running");
    a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        chan_init_reg |=> chan_init_reg)
        else $error("channel memory init flag dropped");
    a_wr_follows_rd: assert property (@(posedge clk) disable iff (!rst_n)
        copy_act_reg && !ctrl.copy_start |=> wr_pend_reg && wr_addr_reg == $past(copy_cnt_reg))
        else $error("copy write does not follow its staging read");
`endif

endmodule

### sv/rcpf_tx.sv
// Packet serializer: header, channel words, running CRC and output register.
// Depends on rcpf_pkg; reads channel words from rcpf_store.
module rcpf_tx #(
    parameter int CHANNEL_COUNT  = rcpf_pkg::CHANNEL_COUNT_DEF,
    parameter int PROTO_VERSION  = rcpf_pkg::PROTO_VERSION_DEF,
    parameter int THROTTLE_INDEX = rcpf_pkg::THROTTLE_INDEX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rcpf_pkg::tx_cmd_t                  cmd,
    input  rcpf_pkg::link_cfg_t                cfg,
    output logic [$clog2(CHANNEL_COUNT)-1:0]   rd_addr,
    input  logic [15:0]                        rd_word,
    output logic                               busy,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] packet_byte
    output logic                               m_tlast    // byte_last
);
    import rcpf_pkg::*;

    localparam int PKT_LEN = HDR_BYTES + 2 * CHANNEL_COUNT + 2;
    localparam int CNTW    = $clog2(PKT_LEN);
    localparam int CIW     = $clog2(CHANNEL_COUNT);
    localparam int CRC_LO  = PKT_LEN - 2;
    localparam int CHAN_END = HDR_BYTES + 2 * CHANNEL_COUNT;

    logic            gen_act_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [15:0]     crc_reg;
    mode_t           mode_reg;
    logic [15:0]     seq_reg;
    logic [31:0]     now_reg;
    logic            out_valid_reg;
    logic [7:0]      out_data_reg;
    logic            out_last_reg;

    logic            load;
    logic [CNTW-1:0] cnt_next;
    logic [CNTW-1:0] nxt_ofs;
    logic [CNTW-1:0] cur_ofs;
    logic [CIW-1:0]  cur_idx;
    logic [7:0]      flags;
    logic [143:0]    hdr_vec;
    logic [4:0]      hdr_sel;
    logic [15:0]     word;
    logic [7:0]      pkt_byte;
    logic            is_last;

    assign load    = gen_act_reg && (!out_valid_reg || m_tready);
    assign is_last = (cnt_reg == CNTW'(PKT_LEN - 1));
    assign busy    = gen_act_reg;

    always_comb
    begin
        if (cmd.start)
        begin
            cnt_next = '0;
        end
        else if (load)
        begin
            cnt_next = CNTW'(cnt_reg + 1'b1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // Address the channel memory in the cycle before the byte that needs it
    assign nxt_ofs = cnt_next - CNTW'(HDR_BYTES);
    assign rd_addr = (cnt_next >= CNTW'(HDR_BYTES) && cnt_next < CNTW'(CHAN_END))
                   ? nxt_ofs[CIW:1] : '0;

    always_comb
    begin
        unique case (mode_reg)
            MODE_DIRECT:  flags = FLAGS_DIRECT;
            MODE_TRAINER: flags = FLAGS_TRAINER;
            default:      flags = FLAGS_IDLE;
        endcase
    end

    assign hdr_vec = {now_reg, seq_reg, 8'h00, flags, 8'(CHANNEL_COUNT),
                      8'(PROTO_VERSION), cfg.ident, cfg.magic};
    assign hdr_sel = (cnt_reg < CNTW'(HDR_BYTES)) ? cnt_reg[4:0] : 5'd0;

    assign cur_ofs = cnt_reg - CNTW'(HDR_BYTES);
    assign cur_idx = cur_ofs[CIW:1];

    always_comb
    begin
        if (mode_reg != MODE_NONE)
        begin
            word = rd_word;
        end
        else if (5'(cur_idx) == 5'(THROTTLE_INDEX))
        begin
            word = cfg.min_us;
        end
        else
        begin
            word = cfg.mid_us;
        end
    end

    always_comb
    begin
        priority if (cnt_reg < CNTW'(HDR_BYTES))
        begin
            pkt_byte = hdr_vec[{hdr_sel, 3'b000} +: 8];
        end
        else if (cnt_reg < CNTW'(CRC_LO))
        begin
            pkt_byte = cur_ofs[0] ? word[15:8] : word[7:0];
        end
        else if (cnt_reg == CNTW'(CRC_LO))
        begin
            pkt_byte = crc_reg[7:0];
        end
        else
        begin
            pkt_byte = crc_reg[15:8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_act_reg   <= 1'b0;
            cnt_reg       <= '0;
            crc_reg       <= CRC_INIT;
            mode_reg      <= MODE_NONE;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.start)
            begin
                gen_act_reg <= 1'b1;
                crc_reg     <= CRC_INIT;
                mode_reg    <= cmd.mode;
            end
            else if (load)
            begin
                if (is_last)
                begin
                    gen_act_reg <= 1'b0;
                end
                if (cnt_reg < CNTW'(CRC_LO))
                begin
                    crc_reg <= crc16_byte(crc_reg, pkt_byte);
                end
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                out_last_reg  <= is_last;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            seq_reg <= cmd.seq;
            now_reg <= cmd.now;
        end
        if (load)
        begin
            out_data_reg <= pkt_byte;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> !gen_act_reg)
        else $error("packet launched while a packet is in progress");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        gen_act_reg |-> cnt_reg < CNTW'(PKT_LEN))
        else $error("byte counter past packet end");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        load && is_last |=> !gen_act_reg && m_tvalid && m_tlast)
        else $error("final byte did not close the packet");
    a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> cnt_reg == '0 && crc_reg == CRC_INIT)
        else $error("packet did not start at byte zero with fresh CRC");
`endif

endmodule
